>>> src/svm_pkg.sv
// Shared types, request codes and elaboration helpers for the sample voice mixer.
// Used by svm_ctrl, svm_datapath and sample_voice_mixer_top; depends on nothing.
package svm_pkg;

  // Request codes carried in req_type. Codes five to seven do nothing.
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_ONESHOT = 3'd1;
  localparam logic [2:0] REQ_LOOP    = 3'd2;
  localparam logic [2:0] REQ_STOP    = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // Largest value of a 14-bit address field.
  localparam int ADDR_MAX = 16383;

  // Stored samples are the input divided by four, so they need 30 bits.
  localparam int STORE_W = 30;

  // One input beat.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [13:0]        mem_address;
    logic signed [31:0] sample_value;
    logic [13:0]        wave_start;
    logic [14:0]        wave_length;
    logic [1:0]         voice_select;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] mix_sample;
    logic [1:0]         granted_voice;
    logic               granted;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mod_step;
    logic wr;
    logic claim;
    logic stop;
    logic rd_en;
    logic finish;
  } cmd_t;

  // Number of compare-and-subtract steps that reduce a 14-bit address modulo
  // the memory depth: one step for each shifted copy of the depth that still
  // fits at or below the largest address.
  function automatic int mod_steps(input int depth);
    int n;
    n = 0;
    for (int k = 0; k < 15; k++) begin
      if ((longint'(depth) << k) <= longint'(ADDR_MAX)) n = k + 1;
    end
    return n;
  endfunction

endpackage

>>> src/svm_ctrl.sv
// Sequencer for the sample voice mixer: accepts requests and steps the datapath.
// Depends on svm_pkg for the request codes and the command struct.
module svm_ctrl #(
  parameter int VOICES    = 4,
  parameter int MOD_STEPS = 1,
  parameter int SW        = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        req_type,
  output logic              busy,
  output logic              done,
  output svm_pkg::cmd_t     cmd,
  output logic [SW-1:0]     slot
);

  localparam int SLOTS = 2 * VOICES;
  localparam int CNT_A = (SLOTS > MOD_STEPS) ? SLOTS : MOD_STEPS;
  localparam int CW    = (CNT_A > 1) ? $clog2(CNT_A) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_READ,
    S_ADD,
    S_FIN
  } state_t;

  state_t        state;
  logic [2:0]    kind;
  logic [CW-1:0] count;

  // State, step counter and the registered result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= svm_pkg::REQ_WRITE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            kind  <= req_type;
            count <= '0;
            if (req_type inside {svm_pkg::REQ_WRITE, svm_pkg::REQ_ONESHOT,
                                 svm_pkg::REQ_LOOP}) begin
              state <= (MOD_STEPS > 0) ? S_MOD : S_EXEC;
            end else if (req_type == svm_pkg::REQ_STOP) begin
              state <= S_EXEC;
            end else if (req_type == svm_pkg::REQ_TICK) begin
              state <= S_READ;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MOD: begin
          if (count == CW'(MOD_STEPS - 1)) begin
            count <= '0;
            state <= S_EXEC;
          end else begin
            count <= count + 1'b1;
          end
        end
        S_EXEC: state <= S_FIN;
        S_READ: begin
          if (count == CW'(SLOTS - 1)) begin
            count <= '0;
            state <= S_ADD;
          end else begin
            count <= count + 1'b1;
          end
        end
        S_ADD:   state <= S_FIN;
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign slot = SW'(count);

  // Datapath commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.load     = start && (state == S_IDLE);
    cmd.mod_step = (state == S_MOD);
    cmd.wr       = (state == S_EXEC) && (kind == svm_pkg::REQ_WRITE);
    cmd.claim    = (state == S_EXEC) &&
                   ((kind == svm_pkg::REQ_ONESHOT) || (kind == svm_pkg::REQ_LOOP));
    cmd.stop     = (state == S_EXEC) && (kind == svm_pkg::REQ_STOP);
    cmd.rd_en    = (state == S_READ);
    cmd.finish   = (state == S_FIN);
  end

  // Each request gives exactly one strobe, never two in a row.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The last state of every request is followed by the strobe and a free block.
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (done && !busy))
    else $error("result strobe missing after finish");

endmodule

>>> src/svm_datapath.sv
// Datapath of the sample voice mixer: sample memory, voice registers, address
// reduction unit and mix accumulator. Depends on svm_pkg.
module svm_datapath #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int VOICES       = 4,
  parameter int MOD_STEPS    = 1,
  parameter int SW           = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  svm_pkg::req_t    req,
  input  svm_pkg::cmd_t    cmd,
  input  logic [SW-1:0]    slot,
  output svm_pkg::res_t    res
);

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int SLOTS = 2 * VOICES;
  localparam int ACC_W = svm_pkg::STORE_W + 1 + $clog2(SLOTS);
  localparam int DSH   = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;
  localparam logic [13:0] DIV_INIT =
    (MOD_STEPS > 0) ? 14'(longint'(SAMPLE_DEPTH) << DSH) : 14'd0;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  // Latched request and derived values.
  svm_pkg::req_t                     r;
  logic signed [svm_pkg::STORE_W-1:0] quarter;
  logic [13:0]                       mod_val;
  logic [13:0]                       divisor;
  logic signed [31:0]                biased;

  // Sample memory.
  logic signed [svm_pkg::STORE_W-1:0] mem [SAMPLE_DEPTH];
  logic signed [svm_pkg::STORE_W-1:0] rd_data;
  logic [AW-1:0]                     wr_addr;
  logic [AW-1:0]                     rd_addr;

  // Voice registers; slot bit zero is the kind (zero one-shot, one loop).
  logic          active [SLOTS];
  logic [AW-1:0] vstart [SLOTS];
  logic [AW-1:0] vaddr  [SLOTS];
  logic [14:0]   vlen   [SLOTS];
  logic [13:0]   vpos   [SLOTS];

  // Claim, advance and mix signals.
  logic                    loop_kind;
  logic                    free_found;
  logic [SW-1:0]           free_slot;
  logic [1:0]              free_voice;
  logic                    grant_ok_c;
  logic                    grant_ok;
  logic [1:0]              grant_idx;
  logic [SW-1:0]           stop_slot;
  logic                    stop_ok;
  logic [14:0]             pos_inc;
  logic [AW:0]             addr_inc;
  logic [AW-1:0]           addr_next;
  logic                    wave_end;
  logic                    rd_pend;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      sat_val;

  // Divide by four toward zero: bias negative values by three before the shift.
  assign biased = req.sample_value + 32'(req.sample_value[31] ? 2'd3 : 2'd0);

  // Request latch and the address reduction unit, one compare-subtract a step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r       <= req;
      quarter <= biased[31:2];
      mod_val <= (req.req_type == svm_pkg::REQ_WRITE) ? req.mem_address : req.wave_start;
      divisor <= DIV_INIT;
    end else if (cmd.mod_step) begin
      if (mod_val >= divisor) mod_val <= mod_val - divisor;
      divisor <= divisor >> 1;
    end
  end

  assign wr_addr = AW'(mod_val);
  assign rd_addr = vaddr[slot];

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[wr_addr] <= quarter;
    rd_data <= mem[rd_addr];
  end

  // Lowest free voice of the requested kind.
  assign loop_kind = (r.req_type == svm_pkg::REQ_LOOP);

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    free_voice = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active[SW'(2 * v + int'(loop_kind))]) begin
        free_found = 1'b1;
        free_slot  = SW'(2 * v + int'(loop_kind));
        free_voice = 2'(v);
      end
    end
  end

  assign grant_ok_c = free_found && (r.wave_length != 15'd0);
  assign stop_ok    = int'(r.voice_select) < VOICES;
  assign stop_slot  = SW'(2 * int'(r.voice_select) + 1);

  // Position and address of the voice being read, one step on.
  assign pos_inc   = {1'b0, vpos[slot]} + 15'd1;
  assign wave_end  = (pos_inc >= vlen[slot]);
  assign addr_inc  = {1'b0, vaddr[slot]} + 1'b1;
  assign addr_next = (addr_inc == (AW + 1)'(SAMPLE_DEPTH)) ? '0 : addr_inc[AW-1:0];

  // Voice activity flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) active[s] <= 1'b0;
    end else if (cmd.claim && grant_ok_c) begin
      active[free_slot] <= 1'b1;
    end else if (cmd.stop && stop_ok) begin
      active[stop_slot] <= 1'b0;
    end else if (cmd.rd_en && active[slot] && wave_end && !slot[0]) begin
      active[slot] <= 1'b0;
    end
  end

  // Voice start, length, position and memory address.
  always_ff @(posedge clk) begin
    if (cmd.claim && grant_ok_c) begin
      vstart[free_slot] <= AW'(mod_val);
      vaddr[free_slot]  <= AW'(mod_val);
      vlen[free_slot]   <= r.wave_length;
      vpos[free_slot]   <= '0;
    end else if (cmd.rd_en && active[slot]) begin
      if (wave_end) begin
        vpos[slot]  <= '0;
        vaddr[slot] <= vstart[slot];
      end else begin
        vpos[slot]  <= pos_inc[13:0];
        vaddr[slot] <= addr_next;
      end
    end
  end

  // Grant record of a start request.
  always_ff @(posedge clk) begin
    if (rst) begin
      grant_ok <= 1'b0;
    end else if (cmd.load) begin
      grant_ok <= 1'b0;
    end else if (cmd.claim) begin
      grant_ok <= grant_ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim) grant_idx <= free_voice;
  end

  // Mix accumulator: adds the sample read in the previous cycle when its voice was active.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en && active[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (rd_pend) begin
      acc <= acc + ACC_W'(rd_data);
    end
  end

  // Saturate the mix to 32 bits.
  always_comb begin
    if (acc > SAT_HI) begin
      sat_val = 32'sh7fff_ffff;
    end else if (acc < SAT_LO) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = acc[31:0];
    end
  end

  // Result register, loaded once per request.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.mix_sample    <= (r.req_type == svm_pkg::REQ_TICK) ? sat_val : 32'sd0;
      res.granted       <= grant_ok;
      res.granted_voice <= grant_ok ? grant_idx : 2'd0;
    end
  end

  // No memory read may still be on its way when the result is formed.
  a_no_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !rd_pend)
    else $error("result formed with a sample read in flight");

  // Only a tick yields a nonzero mix.
  a_mix_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (r.req_type != svm_pkg::REQ_TICK)) |=> (res.mix_sample == 32'sd0))
    else $error("nonzero mix on a request other than a tick");

  // A granted claim leaves the chosen voice active.
  a_claim_active: assert property (@(posedge clk) disable iff (rst)
    (cmd.claim && grant_ok_c) |=> active[$past(free_slot)])
    else $error("claimed voice is not active");

endmodule

>>> src/sample_voice_mixer_top.sv
// Top level of the sample voice mixer: joins the sequencer and the datapath.
// Depends on svm_pkg, svm_ctrl and svm_datapath.
//
// Usage: drive a request on req and raise start; it is taken at a rising edge
// where start is high and busy is low. Exactly one result beat follows: done
// is high for one cycle with res valid, and the receiver must take it then.
// Sample writes store the value divided by four; start requests claim the
// lowest free voice of their kind; stop frees a loop voice; a tick reads the
// current sample of every active voice, sums and saturates the mix, and
// advances the voices.
// Steps from accept to done, while busy is high:
//   write, one-shot or loop start: MOD_STEPS reduction steps, execute and finish,
//   where MOD_STEPS is the number of compare-subtract steps of the address reducer;
//   stop: execute and finish; unknown codes: finish only;
//   tick: reads of all 2 * VOICES voice slots in turn, then an add and finish;
//   reads share the single sample memory read port, one voice slot per cycle.
// busy may fall in the same cycle that done is shown, so a new request can be
// taken while a result is on the ports.
// Reset frees every voice; the sample memory is not cleared and
// must be written before a voice plays it.
module sample_voice_mixer_top #(
  parameter int SAMPLE_DEPTH = 16384,
  parameter int VOICES       = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  svm_pkg::req_t  req,
  output logic           done,
  output svm_pkg::res_t  res
);

  localparam int MOD_STEPS = svm_pkg::mod_steps(SAMPLE_DEPTH);
  localparam int SW        = $clog2(2 * VOICES);

  svm_pkg::cmd_t cmd;
  logic [SW-1:0] slot;

  // Request sequencer.
  svm_ctrl #(
    .VOICES    (VOICES),
    .MOD_STEPS (MOD_STEPS),
    .SW        (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd),
    .slot     (slot)
  );

  // Memory, voices and mixer.
  svm_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .VOICES       (VOICES),
    .MOD_STEPS    (MOD_STEPS),
    .SW           (SW)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .slot (slot),
    .res  (res)
  );

endmodule

>>> tb/sv/sample_voice_mixer_top_test.sv
// Self-checking testbench for sample_voice_mixer_top: directed and random request beats,
// each result checked against a behavioral copy of the mixer state.
// Depends on svm_pkg and the RTL of sample_voice_mixer_top.
module sample_voice_mixer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_DEPTH  = 16384;
  localparam int VOICES        = 4;
  localparam int STORE_DIVISOR = 4;
  localparam int WAVE_MAX      = 16384;
  localparam int WATCHDOG_MAX  = 2000;
  localparam longint MIX_MAX   = 64'sd2147483647;
  localparam longint MIX_MIN   = -64'sd2147483648;

  // Request codes that the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef enum int {ONE_SHOT = 0, LOOPING = 1} voice_kind_t;

  typedef struct {
    bit          active;
    logic [13:0] first;
    logic [14:0] len;
    logic [14:0] pos;
  } voice_t;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  svm_pkg::req_t req   = '0;
  logic          done;
  svm_pkg::res_t res;

  // Mirror of the mixer state, updated as each beat is accepted.
  int     sample_mem [SAMPLE_DEPTH];
  bit     written [SAMPLE_DEPTH];
  voice_t voices [2][VOICES];

  svm_pkg::res_t results_due [$];
  int   mismatches  = 0;
  int   idle_pct    = 0;
  int   idle_cycles = 0;
  int   items_sent  = 0;

  sample_voice_mixer_top dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  always #1 clk = ~clk;

  // Memory address that a voice reads on its next tick.
  function automatic logic [13:0] voice_addr(input voice_t vc);
    return vc.first + vc.pos[13:0];
  endfunction

  // Applies one request to the mirrored state and returns the result it produces.
  function automatic svm_pkg::res_t mixer_result(input svm_pkg::req_t r);
    svm_pkg::res_t o;
    longint        acc;
    bit            found;
    voice_kind_t   kind;
    o     = '0;
    acc   = 0;
    found = 1'b0;
    case (r.req_type)
      svm_pkg::REQ_WRITE: begin
        sample_mem[r.mem_address] = int'(r.sample_value) / STORE_DIVISOR;
        written[r.mem_address]    = 1'b1;
      end
      svm_pkg::REQ_ONESHOT, svm_pkg::REQ_LOOP: begin
        kind = (r.req_type == svm_pkg::REQ_ONESHOT) ? ONE_SHOT : LOOPING;
        if (r.wave_length != 0) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!found && !voices[kind][v].active) begin
              found                   = 1'b1;
              voices[kind][v].active  = 1'b1;
              voices[kind][v].first   = r.wave_start;
              voices[kind][v].len     = r.wave_length;
              voices[kind][v].pos     = '0;
              o.granted               = 1'b1;
              o.granted_voice         = 2'(v);
            end
          end
        end
      end
      svm_pkg::REQ_STOP: begin
        voices[LOOPING][r.voice_select].active = 1'b0;
        voices[LOOPING][r.voice_select].pos    = '0;
      end
      svm_pkg::REQ_TICK: begin
        // Every active voice reads its current sample, then advances.
        for (int v = 0; v < VOICES; v++) begin
          for (int k = 0; k < 2; k++) begin
            if (voices[k][v].active) begin
              acc += sample_mem[voice_addr(voices[k][v])];
              voices[k][v].pos = voices[k][v].pos + 15'd1;
              if (voices[k][v].pos >= voices[k][v].len) begin
                voices[k][v].pos = '0;
                if (k == ONE_SHOT) voices[k][v].active = 1'b0;
              end
            end
          end
        end
        if (acc > MIX_MAX) acc = MIX_MAX;
        if (acc < MIX_MIN) acc = MIX_MIN;
        o.mix_sample = acc[31:0];
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Each result beat is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    svm_pkg::res_t due;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("unexpected result beat: mix_sample %0d granted %0b granted_voice %0d",
               res.mix_sample, res.granted, res.granted_voice);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        if (res.mix_sample !== due.mix_sample) begin
          $error("mix_sample: expected %0d, got %0d", due.mix_sample, res.mix_sample);
          mismatches++;
        end
        if (res.granted_voice !== due.granted_voice) begin
          $error("granted_voice: expected %0d, got %0d", due.granted_voice, res.granted_voice);
          mismatches++;
        end
        if (res.granted !== due.granted) begin
          $error("granted: expected %0b, got %0b", due.granted, res.granted);
          mismatches++;
        end
      end
    end
  end

  // The run ends if no beat moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_MAX) begin
        $display("sample_voice_mixer_top_test: done, errors");
        $finish;
      end
    end
  end

  function automatic svm_pkg::req_t random_fields();
    svm_pkg::req_t r;
    r.req_type     = 3'($urandom);
    r.mem_address  = 14'($urandom);
    r.sample_value = $urandom;
    r.wave_start   = 14'($urandom);
    r.wave_length  = 15'($urandom_range(0, WAVE_MAX));
    r.voice_select = 2'($urandom);
    return r;
  endfunction

  // Sample values lean toward the extremes so that the mix saturates now and then.
  function automatic logic signed [31:0] random_sample();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return int'($urandom_range(0, 64)) - 32;
      default: return $urandom;
    endcase
  endfunction

  // Addresses cluster at both ends of memory so that waves reuse written samples.
  function automatic logic [13:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 14'($urandom_range(0, 255));
      1:       return 14'($urandom_range(svm_pkg::ADDR_MAX - 255, svm_pkg::ADDR_MAX));
      default: return 14'($urandom);
    endcase
  endfunction

  // Mostly short waves; loops sometimes span the whole legal length range.
  function automatic logic [14:0] pick_length(input logic [2:0] kind);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (kind == svm_pkg::REQ_LOOP && roll < 3) return 15'($urandom_range(0, WAVE_MAX));
    if (roll < 6) return 15'($urandom_range(17, 300));
    return 15'($urandom_range(1, 16));
  endfunction

  // Sends one beat, with random sender gaps, and records its expected result.
  task automatic send_item(input svm_pkg::req_t r);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(1, 100) <= idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    req   = r;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    items_sent++;
    results_due.push_back(mixer_result(r));
  endtask

  task automatic do_write(input logic [13:0] addr, input logic signed [31:0] value);
    svm_pkg::req_t r;
    r              = random_fields();
    r.req_type     = svm_pkg::REQ_WRITE;
    r.mem_address  = addr;
    r.sample_value = value;
    send_item(r);
  endtask

  task automatic do_start(input logic [2:0] kind, input logic [13:0] first,
                          input logic [14:0] len);
    svm_pkg::req_t r;
    r             = random_fields();
    r.req_type    = kind;
    r.wave_start  = first;
    r.wave_length = len;
    send_item(r);
  endtask

  task automatic do_stop(input logic [1:0] v);
    svm_pkg::req_t r;
    r              = random_fields();
    r.req_type     = svm_pkg::REQ_STOP;
    r.voice_select = v;
    send_item(r);
  endtask

  task automatic send_unused_code(input logic [2:0] code);
    svm_pkg::req_t r;
    r          = random_fields();
    r.req_type = code;
    send_item(r);
  endtask

  // Before a tick, any sample an active voice is about to read gets written first.
  task automatic play_tick();
    svm_pkg::req_t r;
    for (int v = 0; v < VOICES; v++) begin
      for (int k = 0; k < 2; k++) begin
        if (voices[k][v].active && !written[voice_addr(voices[k][v])])
          do_write(voice_addr(voices[k][v]), random_sample());
      end
    end
    r          = random_fields();
    r.req_type = svm_pkg::REQ_TICK;
    send_item(r);
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Store truncation toward zero at both signed extremes and small values; unused codes.
  task automatic test_store_rounding();
    do_write(14'd0, 32'sh7fffffff);
    do_write(14'(svm_pkg::ADDR_MAX), 32'sh80000000);
    do_write(14'd1, -32'sd5);
    do_write(14'd2, 32'sd7);
    send_unused_code(REQ_UNUSED_LO);
    send_unused_code(REQ_UNUSED_HI);
  endtask

  // Zero length, a one-shot whose wave would wrap past the top address, a full-length loop,
  // and stops of both an active and an idle loop voice.
  task automatic test_start_wrap_and_stop();
    do_start(svm_pkg::REQ_ONESHOT, 14'd5, 15'd0);
    do_start(svm_pkg::REQ_ONESHOT, 14'(svm_pkg::ADDR_MAX - 1), 15'd4);
    do_start(svm_pkg::REQ_LOOP, 14'd0, 15'(WAVE_MAX));
    play_tick();
    play_tick();
    do_stop(2'd0);
    do_stop(2'd3);
  endtask

  // All eight voices on the largest stored sample, so the mix clips high;
  // extra starts of both kinds find no free voice.
  task automatic test_full_and_saturation();
    for (int v = 0; v < VOICES; v++) do_start(svm_pkg::REQ_LOOP, 14'd0, 15'd1);
    do_start(svm_pkg::REQ_LOOP, 14'd0, 15'd1);
    for (int v = 0; v < VOICES; v++) do_start(svm_pkg::REQ_ONESHOT, 14'd0, 15'd1);
    play_tick();
  endtask

  // Mostly well-formed traffic with random content, plus ignored codes and
  // occasional full drains; runs until count beats have been sent.
  task automatic test_random_traffic(input int gap_pct, input int count);
    int roll;
    int first_item;
    idle_pct   = gap_pct;
    first_item = items_sent;
    while (items_sent - first_item < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 28)
        do_write(pick_addr(), random_sample());
      else if (roll < 40)
        do_start(svm_pkg::REQ_ONESHOT, pick_addr(), pick_length(svm_pkg::REQ_ONESHOT));
      else if (roll < 52)
        do_start(svm_pkg::REQ_LOOP, pick_addr(), pick_length(svm_pkg::REQ_LOOP));
      else if (roll < 60)
        do_stop(2'($urandom));
      else if (roll < 95)
        play_tick();
      else
        send_unused_code(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_store_rounding();
    test_start_wrap_and_stop();
    test_full_and_saturation();
    wait_drained();

    test_random_traffic(0, 270);
    test_random_traffic(64, 270);
    test_random_traffic(0, 270);
    test_random_traffic(25, 270);

    wait_drained();
    repeat (4 * VOICES + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("sample_voice_mixer_top_test: done, clean");
    end else begin
      $display("sample_voice_mixer_top_test: done, errors");
    end
    $finish;
  end

endmodule

>>> sample_voice_mixer_top.f
src/svm_pkg.sv
src/svm_ctrl.sv
src/svm_datapath.sv
src/sample_voice_mixer_top.sv
tb/sv/sample_voice_mixer_top_test.sv
